// ----- sv/prd_pkg.sv -----
// Shared constants and status codes for the palette RLE pixel decoder.
// No dependencies; imported by the decoder top level.
`default_nettype none

package prd_pkg;

    // Parameter defaults
    localparam int unsigned PRD_PALETTE_DEPTH = 256;
    localparam int unsigned PRD_MAX_PIXELS    = 16384;

    // Field widths fixed by the stream format
    localparam int unsigned PIX_W    = 15;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COLOR_W  = 16;
    localparam int unsigned STATUS_W = 3;

    // Reset value of the frame pixel total
    localparam logic [PIX_W-1:0] PIXEL_TOTAL_RESET = 15'd12288;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_CODEC_MODE  = 1'b0,
        CFG_PIXEL_TOTAL = 1'b1
    } cfg_index_t;

    // Frame status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_OVERRUN  = 3'd1,
        ST_BADIDX   = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_TRAIL    = 3'd4
    } status_t;

endpackage

`default_nettype wire

// ----- sv/prd_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the palette store.
`default_nettype none

module prd_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/palette_rle_pixel_decoder.sv -----
// Palette / raw RGB565 run-literal decoder, one encoded byte per cycle while enc_stall is low.
// A result is registered in the palette RAM read stage, then in the output register,
// once its byte is taken. Throughput: one byte per cycle unless enc_stall holds the input.
// The palette RAM's registered read port sets the extra stage.
// Reset clears the frame state, configuration and valid flags to their defaults; palette
// contents are undefined until a palette is loaded.
// Depends on prd_pkg and prd_ram.
`default_nettype none

module palette_rle_pixel_decoder
    import prd_pkg::*;
#(
    parameter int unsigned PALETTE_DEPTH = PRD_PALETTE_DEPTH,
    parameter int unsigned MAX_PIXELS    = PRD_MAX_PIXELS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Encoded byte channel
    input  wire logic                 enc_valid,
    output logic                      enc_stall,
    input  wire logic [BYTE_W-1:0]    encoded_byte,
    input  wire logic                 is_last,
    // Pixel result channel
    output logic                      pix_valid,
    input  wire logic                 pix_stall,
    output logic [COLOR_W-1:0]        pixel_value,
    output logic [BYTE_W-1:0]         repeat_count,
    output logic                      frame_end,
    output logic [STATUS_W-1:0]       status,
    // Configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [0:0]           cfg_index,
    input  wire logic [PIX_W-1:0]     cfg_data
);

    localparam int unsigned AW = $clog2(PALETTE_DEPTH);
    localparam int unsigned CAP = (MAX_PIXELS > 32767) ? 32767 : MAX_PIXELS;
    localparam logic [PIX_W-1:0] CAP_V = CAP[PIX_W-1:0];
    localparam logic [8:0] DEPTH_V = PALETTE_DEPTH[8:0];
    localparam logic [PIX_W-1:0] EFF_RESET =
        (PIXEL_TOTAL_RESET > CAP_V) ? CAP_V : PIXEL_TOTAL_RESET;

    typedef enum logic [2:0] {
        PH_START,
        PH_PAL,
        PH_CTRL,
        PH_RUN,
        PH_LIT
    } phase_t;

    // Configuration
    logic             codec_mode_reg;
    logic [PIX_W-1:0] eff_total_reg;

    // Frame state
    phase_t            phase_reg, phase_next;
    logic [8:0]        pal_size_reg, pal_size_next;
    logic [7:0]        load_idx_reg, load_idx_next;
    logic [7:0]        packet_left_reg, packet_left_next;
    logic [7:0]        low_hold_reg, low_hold_next;
    logic              byte_half_reg, byte_half_next;
    logic [PIX_W-1:0]  pixels_done_reg, pixels_done_next;
    status_t           error_reg, error_next;

    // RAM-read stage
    logic               s1_valid_reg;
    logic               s1_use_pal_reg;
    logic [COLOR_W-1:0] s1_raw_reg;
    logic [7:0]         s1_rep_reg;
    logic               s1_end_reg;
    status_t            s1_status_reg;

    // Output register
    logic               out_valid_reg;
    logic [COLOR_W-1:0] out_pixel_reg;
    logic [7:0]         out_rep_reg;
    logic               out_end_reg;
    status_t            out_status_reg;

    logic               accept;
    logic               s1_advance;
    logic               emit;
    logic               use_pal;
    logic [COLOR_W-1:0] raw_value;
    logic [7:0]         rep;
    status_t            st;
    logic               ram_rd;
    logic               ram_wr;
    logic [COLOR_W-1:0] ram_q;
    logic [7:0]         ctrl_len;
    logic [PIX_W-1:0]   remaining;
    logic               ctrl_trail;
    logic               ctrl_over;
    logic               bad_index;

    // Handshakes: stall input only when the read stage is full and cannot drain
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !pix_stall);
    assign enc_stall  = s1_valid_reg && out_valid_reg && pix_stall;
    assign accept     = enc_valid && !enc_stall;
    assign cfg_ready  = 1'b1;

    // Control byte decode
    assign ctrl_len   = {1'b0, encoded_byte[6:0]} + 8'd1;
    assign remaining  = eff_total_reg - pixels_done_reg;
    assign ctrl_trail = pixels_done_reg >= eff_total_reg;
    assign ctrl_over  = {{(PIX_W-8){1'b0}}, ctrl_len} > remaining;
    assign bad_index  = ({1'b0, encoded_byte} >= pal_size_reg) ||
                        ({1'b0, encoded_byte} >= DEPTH_V);

    // Decode one byte against the frame state
    always_comb
    begin
        logic got;
        got              = 1'b0;
        phase_next       = phase_reg;
        pal_size_next    = pal_size_reg;
        load_idx_next    = load_idx_reg;
        packet_left_next = packet_left_reg;
        low_hold_next    = low_hold_reg;
        byte_half_next   = byte_half_reg;
        pixels_done_next = pixels_done_reg;
        error_next       = error_reg;
        use_pal          = 1'b0;
        raw_value        = '0;
        rep              = '0;
        st               = ST_OK;
        emit             = 1'b0;
        ram_rd           = 1'b0;
        ram_wr           = 1'b0;

        if (error_reg == ST_OK)
        begin
            case (phase_reg)
                PH_START, PH_CTRL:
                begin
                    if (phase_reg == PH_START && codec_mode_reg)
                    begin
                        pal_size_next  = {1'b0, encoded_byte} + 9'd1;
                        load_idx_next  = '0;
                        byte_half_next = 1'b0;
                        phase_next     = PH_PAL;
                    end
                    else
                    begin
                        phase_next = PH_CTRL;
                        if (ctrl_trail)
                        begin
                            error_next = ST_TRAIL;
                        end
                        else if (ctrl_over)
                        begin
                            error_next = ST_OVERRUN;
                        end
                        else
                        begin
                            packet_left_next = ctrl_len;
                            byte_half_next   = 1'b0;
                            phase_next       = encoded_byte[7] ? PH_RUN : PH_LIT;
                        end
                    end
                end
                PH_PAL:
                begin
                    if (!byte_half_reg)
                    begin
                        low_hold_next  = encoded_byte;
                        byte_half_next = 1'b1;
                    end
                    else
                    begin
                        byte_half_next = 1'b0;
                        ram_wr = {1'b0, load_idx_reg} < DEPTH_V;
                        if ({1'b0, load_idx_reg} + 9'd1 >= pal_size_reg)
                        begin
                            phase_next = PH_CTRL;
                        end
                        else
                        begin
                            load_idx_next = load_idx_reg + 8'd1;
                        end
                    end
                end
                default:
                begin
                    // Value byte for a run or literal packet
                    if (codec_mode_reg)
                    begin
                        byte_half_next = 1'b0;
                        if (bad_index)
                        begin
                            error_next = ST_BADIDX;
                        end
                        else
                        begin
                            got     = 1'b1;
                            use_pal = 1'b1;
                            ram_rd  = 1'b1;
                        end
                    end
                    else if (!byte_half_reg)
                    begin
                        low_hold_next  = encoded_byte;
                        byte_half_next = 1'b1;
                    end
                    else
                    begin
                        byte_half_next = 1'b0;
                        got            = 1'b1;
                        raw_value      = {encoded_byte, low_hold_reg};
                    end

                    if (got)
                    begin
                        if (phase_reg == PH_RUN)
                        begin
                            rep              = packet_left_reg;
                            pixels_done_next = pixels_done_reg +
                                               {{(PIX_W-8){1'b0}}, packet_left_reg};
                            packet_left_next = '0;
                            phase_next       = PH_CTRL;
                        end
                        else
                        begin
                            rep              = 8'd1;
                            pixels_done_next = pixels_done_reg + {{(PIX_W-1){1'b0}}, 1'b1};
                            packet_left_next = packet_left_reg - 8'd1;
                            if (packet_left_reg == 8'd1)
                            begin
                                phase_next = PH_CTRL;
                            end
                        end
                    end
                end
            endcase
        end

        // Last byte: report status and clear the frame
        if (is_last)
        begin
            emit = 1'b1;
            if (error_next == ST_OK &&
                !(phase_next == PH_CTRL && pixels_done_next == eff_total_reg))
            begin
                st = ST_TRUNC;
            end
            else
            begin
                st = error_next;
            end
            phase_next       = PH_START;
            pal_size_next    = '0;
            load_idx_next    = '0;
            packet_left_next = '0;
            low_hold_next    = '0;
            byte_half_next   = 1'b0;
            pixels_done_next = '0;
            error_next       = ST_OK;
        end
        else
        begin
            emit = got;
        end
    end

    // Palette store
    prd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (accept && ram_wr),
        .wr_addr (load_idx_reg[AW-1:0]),
        .wr_data ({encoded_byte, low_hold_reg}),
        .rd_en   (accept && ram_rd),
        .rd_addr (encoded_byte[AW-1:0]),
        .rd_data (ram_q)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_mode_reg <= 1'b0;
            eff_total_reg  <= EFF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CODEC_MODE:  codec_mode_reg <= cfg_data[0];
                CFG_PIXEL_TOTAL: eff_total_reg  <= (cfg_data > CAP_V) ? CAP_V : cfg_data;
                default:         codec_mode_reg <= codec_mode_reg;
            endcase
        end
    end

    // Advance frame state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            pal_size_reg    <= '0;
            load_idx_reg    <= '0;
            packet_left_reg <= '0;
            low_hold_reg    <= '0;
            byte_half_reg   <= 1'b0;
            pixels_done_reg <= '0;
            error_reg       <= ST_OK;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            pal_size_reg    <= pal_size_next;
            load_idx_reg    <= load_idx_next;
            packet_left_reg <= packet_left_next;
            low_hold_reg    <= low_hold_next;
            byte_half_reg   <= byte_half_next;
            pixels_done_reg <= pixels_done_next;
            error_reg       <= error_next;
        end
    end

    // Read stage: hold the result while the palette read completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            s1_use_pal_reg <= use_pal;
            s1_raw_reg     <= raw_value;
            s1_rep_reg     <= rep;
            s1_end_reg     <= is_last;
            s1_status_reg  <= st;
        end
    end

    // Output register: load from the read stage, drop on downstream take
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!pix_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_pixel_reg  <= s1_use_pal_reg ? ram_q : s1_raw_reg;
            out_rep_reg    <= s1_rep_reg;
            out_end_reg    <= s1_end_reg;
            out_status_reg <= s1_status_reg;
        end
    end

    assign pix_valid    = out_valid_reg;
    assign pixel_value  = out_pixel_reg;
    assign repeat_count = out_rep_reg;
    assign frame_end    = out_end_reg;
    assign status       = out_status_reg;

endmodule

`default_nettype wire

// ----- tb/sv/palette_rle_pixel_decoder_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for palette_rle_pixel_decoder: raw and palette RLE frames,
// a decode predictor with its own palette copy, and random idling on both channels.
// Depends on prd_pkg and the decoder RTL.

module palette_rle_pixel_decoder_test;
    import prd_pkg::*;

    // Stimulus size and frame damage kinds (below FLAW_PACKET the frame is clean)
    localparam int ITEM_BUDGET = 1050;
    localparam int FLAW_NONE   = 0;
    localparam int FLAW_PACKET = 7;
    localparam int FLAW_CUT    = 8;
    localparam int FLAW_TAIL   = 9;

    typedef enum int {
        DEC_START,
        DEC_PALETTE,
        DEC_CONTROL,
        DEC_RUN,
        DEC_LITERAL
    } decode_phase_t;

    typedef struct {
        logic [COLOR_W-1:0] color;
        logic [BYTE_W-1:0]  count;
        logic               fend;
        status_t            st;
    } pixel_result_t;

    // Frame decode predictor and the pixel results still owed by the block
    class pixel_prediction;
        bit                 mode;
        logic [PIX_W-1:0]   total_reg;
        logic [COLOR_W-1:0] palette [PRD_PALETTE_DEPTH];
        int unsigned        pal_size;
        int unsigned        load_idx;
        int unsigned        pkt_left;
        int unsigned        pix_done;
        decode_phase_t      phase;
        bit [7:0]           low_hold;
        bit                 half;
        status_t            err;
        pixel_result_t      pending_pixels[$];
        int                 mismatches;

        function new();
            mode       = 1'b0;
            total_reg  = PIXEL_TOTAL_RESET;
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            phase    = DEC_START;
            pal_size = 0;
            load_idx = 0;
            pkt_left = 0;
            low_hold = 8'h00;
            half     = 1'b0;
            pix_done = 0;
            err      = ST_OK;
        endfunction

        function void set_reg(cfg_index_t idx, logic [PIX_W-1:0] value);
            if (idx == CFG_CODEC_MODE)
                mode = value[0];
            else
                total_reg = value;
        endfunction

        function int unsigned capped_total();
            return (total_reg > PRD_MAX_PIXELS) ? PRD_MAX_PIXELS : total_reg;
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        // Returns 1 with the color once a pixel value is complete
        function bit value_byte(bit [7:0] b, output logic [COLOR_W-1:0] color);
            color = '0;
            if (mode)
            begin
                half = 1'b0;
                if (b >= pal_size || b >= PRD_PALETTE_DEPTH)
                begin
                    err = ST_BADIDX;
                    return 1'b0;
                end
                color = palette[b];
                return 1'b1;
            end
            if (!half)
            begin
                low_hold = b;
                half     = 1'b1;
                return 1'b0;
            end
            half  = 1'b0;
            color = {b, low_hold};
            return 1'b1;
        endfunction

        function void start_packet(bit [7:0] b);
            int unsigned limit;
            int unsigned len;
            limit = capped_total();
            len   = b[6:0] + 1;
            if (pix_done >= limit)
                err = ST_TRAIL;
            else if (len > limit - pix_done)
                err = ST_OVERRUN;
            else
            begin
                pkt_left = len;
                half     = 1'b0;
                phase    = b[7] ? DEC_RUN : DEC_LITERAL;
            end
        endfunction

        // Advance the decode by one accepted byte request
        function void take_byte(bit [7:0] b, bit last);
            pixel_result_t      res;
            logic [COLOR_W-1:0] color;
            int unsigned        reps;
            reps  = 0;
            color = '0;
            res.color = '0;
            if (err == ST_OK)
            begin
                case (phase)
                    DEC_START:
                    begin
                        if (mode)
                        begin
                            pal_size = b + 1;
                            load_idx = 0;
                            half     = 1'b0;
                            phase    = DEC_PALETTE;
                        end
                        else
                        begin
                            phase = DEC_CONTROL;
                            start_packet(b);
                        end
                    end
                    DEC_PALETTE:
                    begin
                        if (!half)
                        begin
                            low_hold = b;
                            half     = 1'b1;
                        end
                        else
                        begin
                            half = 1'b0;
                            if (load_idx < PRD_PALETTE_DEPTH)
                                palette[load_idx] = {b, low_hold};
                            if (load_idx + 1 >= pal_size)
                                phase = DEC_CONTROL;
                            else
                                load_idx = (load_idx + 1) & 8'hFF;
                        end
                    end
                    DEC_CONTROL: start_packet(b);
                    DEC_RUN:
                    begin
                        if (value_byte(b, color))
                        begin
                            res.color = color;
                            reps      = pkt_left;
                            pix_done += pkt_left;
                            pkt_left  = 0;
                            phase     = DEC_CONTROL;
                        end
                    end
                    default:
                    begin
                        if (value_byte(b, color))
                        begin
                            res.color = color;
                            reps      = 1;
                            pix_done += 1;
                            pkt_left  = (pkt_left - 1) & 8'hFF;
                            if (pkt_left == 0)
                                phase = DEC_CONTROL;
                        end
                    end
                endcase
            end
            res.count = reps[7:0];
            if (last)
            begin
                if (err == ST_OK && !(phase == DEC_CONTROL && pix_done == capped_total()))
                    err = ST_TRUNC;
                res.fend = 1'b1;
                res.st   = err;
                pending_pixels.push_back(res);
                clear_frame();
            end
            else if (reps != 0)
            begin
                res.fend = 1'b0;
                res.st   = ST_OK;
                pending_pixels.push_back(res);
            end
        endfunction

        // Compare one accepted pixel result with the oldest one owed
        function void check_pixel(logic [COLOR_W-1:0] color, logic [BYTE_W-1:0] count,
                                  logic fend, logic [STATUS_W-1:0] st);
            pixel_result_t want;
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel result: %h x%0d end=%b status=%0d",
                             color, count, fend, st);
                return;
            end
            want = pending_pixels.pop_front();
            if (color !== want.color || count !== want.count || fend !== want.fend ||
                st !== want.st)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %h x%0d end=%b st=%0d got %h x%0d end=%b st=%0d",
                             want.color, want.count, want.fend, want.st,
                             color, count, fend, st);
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                enc_valid = 1'b0;
    logic                enc_stall;
    logic [BYTE_W-1:0]   encoded_byte = '0;
    logic                is_last = 1'b0;
    logic                pix_valid;
    logic                pix_stall = 1'b0;
    logic [COLOR_W-1:0]  pixel_value;
    logic [BYTE_W-1:0]   repeat_count;
    logic                frame_end;
    logic [STATUS_W-1:0] status;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [0:0]          cfg_index = '0;
    logic [PIX_W-1:0]    cfg_data = '0;

    pixel_prediction pred = new();
    bit [8:0]        frame_bytes[$];
    bit              idle_on = 1'b1;
    int              sent = 0;
    int              stall_left = 0;

    always #5 clk = ~clk;

    palette_rle_pixel_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .enc_valid    (enc_valid),
        .enc_stall    (enc_stall),
        .encoded_byte (encoded_byte),
        .is_last      (is_last),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .pixel_value  (pixel_value),
        .repeat_count (repeat_count),
        .frame_end    (frame_end),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Check accepted pixel results; stall in random bursts
    always @(posedge clk)
    begin
        if (rst_n && pix_valid && !pix_stall)
            pred.check_pixel(pixel_value, repeat_count, frame_end, status);
        if (stall_left != 0)
        begin
            pix_stall <= 1'b1;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            pix_stall  <= 1'b1;
            stall_left = $urandom_range(0, 3);
        end
        else
            pix_stall <= 1'b0;
    end

    // Offer one byte request, with an optional idle burst ahead of it
    task automatic send_byte(input bit [7:0] b, input bit last);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 4);
            enc_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        enc_valid    <= 1'b1;
        encoded_byte <= b;
        is_last      <= last;
        @(posedge clk);
        while (enc_stall) @(posedge clk);
        pred.take_byte(b, last);
        sent++;
        if (last)
        begin
            enc_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Drain the block, let the pipeline settle, then write one register
    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        enc_valid <= 1'b0;
        while (pred.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[PIX_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        pred.set_reg(idx, value[PIX_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    // Build one encoded frame into frame_bytes, damaged according to flaw
    function automatic void build_frame(bit pal_mode, int unsigned eff_total,
                                        bit full_palette, int flaw);
        int unsigned cnt;
        int unsigned psize;
        int unsigned left;
        int unsigned len;
        int unsigned keep;
        bit          run;
        frame_bytes.delete();
        psize = 0;
        if (flaw < 0)
            flaw = $urandom_range(0, FLAW_TAIL);
        if (pal_mode)
        begin
            cnt   = full_palette ? 255 : $urandom_range(0, 15);
            psize = cnt + 1;
            frame_bytes.push_back({1'b0, cnt[7:0]});
            repeat (2 * psize) frame_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
        end
        left = eff_total;
        while (left != 0)
        begin
            if (left > 256 && $urandom_range(0, 7) != 0)
                len = 128;
            else
                len = $urandom_range(1, (left < 128) ? left : 128);
            // Keep long frames short with runs until the tail
            if (left > 256)
                run = 1'b1;
            else if (len > 12)
                run = ($urandom_range(0, 7) != 0);
            else
                run = 1'($urandom_range(0, 1));
            // Break the frame with a bad index or an oversized packet, then noise
            if (flaw == FLAW_PACKET && $urandom_range(0, 2) == 0)
            begin
                if (pal_mode && psize < 256 && (left >= 128 || $urandom_range(0, 1)))
                begin
                    frame_bytes.push_back({1'b0, run, 7'(len - 1)});
                    frame_bytes.push_back({1'b0, 8'($urandom_range(psize, 255))});
                end
                else if (left < 128)
                    frame_bytes.push_back({1'b0, run, 7'($urandom_range(left, 127))});
                else
                    frame_bytes.push_back({1'b0, run, 7'(len - 1)});
                repeat ($urandom_range(0, 3))
                    frame_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
                break;
            end
            frame_bytes.push_back({1'b0, run, 7'(len - 1)});
            repeat (run ? 1 : len)
            begin
                if (pal_mode)
                    frame_bytes.push_back({1'b0, 8'($urandom_range(0, psize - 1))});
                else
                    repeat (2) frame_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
            end
            left -= len;
        end
        if (flaw == FLAW_TAIL)
            repeat ($urandom_range(1, 3))
                frame_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
        if (flaw == FLAW_CUT && frame_bytes.size() > 1)
        begin
            keep = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
        end
        if (frame_bytes.size() == 0)
            frame_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
        frame_bytes[frame_bytes.size() - 1][8] = 1'b1;
    endfunction

    initial
    begin
        int          frame_no;
        int          flaw;
        int          r;
        int unsigned wait_cycles;
        int unsigned new_total;
        bit          new_mode;
        bit          full_pal;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Raw run of three
        write_reg(CFG_CODEC_MODE, 0);
        write_reg(CFG_PIXEL_TOTAL, 3);
        send_byte(8'h82, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // Raw literal of two
        write_reg(CFG_PIXEL_TOTAL, 2);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h12, 1'b1);
        // Overrun, then a control byte after the frame is complete
        write_reg(CFG_PIXEL_TOTAL, 1);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b1);
        // Zero total
        write_reg(CFG_PIXEL_TOTAL, 0);
        send_byte(8'h80, 1'b1);
        // Palette frame with mode switches inside the literal, ends on a bad index
        write_reg(CFG_PIXEL_TOTAL, 3);
        write_reg(CFG_CODEC_MODE, 1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hCD, 1'b0);
        send_byte(8'hAB, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        write_reg(CFG_CODEC_MODE, 0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h11, 1'b0);
        write_reg(CFG_CODEC_MODE, 1);
        send_byte(8'h01, 1'b1);
        // Truncated raw frame
        write_reg(CFG_CODEC_MODE, 0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h12, 1'b1);

        // Random frames; one carries the extreme settings
        frame_no = 0;
        while (sent < ITEM_BUDGET)
        begin
            full_pal  = 1'b0;
            flaw      = -1;
            new_mode  = pred.mode;
            new_total = pred.total_reg;
            case (frame_no)
                1:
                begin
                    new_mode  = 1'b1;
                    new_total = 32767;
                    full_pal  = 1'b1;
                    flaw      = FLAW_NONE;
                end
                default:
                begin
                    if ($urandom_range(0, 2) == 0)
                        new_mode = ~pred.mode;
                    if ($urandom_range(0, 1) || pred.total_reg > 40)
                    begin
                        r = $urandom_range(0, 19);
                        new_total = (r == 0) ? 0 : (r == 1) ? 1 : $urandom_range(2, 40);
                    end
                end
            endcase
            if (new_mode != pred.mode)
                write_reg(CFG_CODEC_MODE, new_mode);
            if (new_total != pred.total_reg)
                write_reg(CFG_PIXEL_TOTAL, new_total);
            build_frame(new_mode, (new_total > PRD_MAX_PIXELS) ? PRD_MAX_PIXELS : new_total,
                        full_pal, flaw);
            foreach (frame_bytes[i])
            begin
                idle_on = (sent + 150 < ITEM_BUDGET);
                send_byte(frame_bytes[i][7:0], frame_bytes[i][8]);
            end
            frame_no++;
        end

        // Drain owed results, then watch for stray ones
        idle_on = 1'b0;
        wait_cycles = 0;
        while (pred.pending() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (pred.mismatches == 0 && pred.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard stop for a hung handshake
    initial
    begin
        #(5_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
